// File: sv/i2c_waveform_event_generator_assert.svh
// ----------------------------------------------------------------------------
// I2C waveform event generator assertion macros
// Concurrent assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef I2C_WAVEFORM_EVENT_GENERATOR_ASSERT_SVH
`define I2C_WAVEFORM_EVENT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define I2CWEG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2cweg assertion failed");

// next-cycle implication
`define I2CWEG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2cweg assertion failed");

`endif

// File: sv/i2cweg_pkg.sv
// ----------------------------------------------------------------------------
// I2C waveform event generator package
// Symbol codes, register indexes, reset values, phase codes and the event type.
// ----------------------------------------------------------------------------
package i2cweg_pkg;

	localparam int TimeW  = 16;
	localparam int DelayW = 17;
	localparam int CfgIdxW = 3;

	typedef enum logic [2:0] {
		REQ_IDLE  = 3'd0,
		REQ_START = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_BIT   = 3'd3,
		REQ_DATA  = 3'd4,
		REQ_ADDR  = 3'd5
	} req_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FALL       = 3'd0,
		CFG_RISE       = 3'd1,
		CFG_START_HOLD = 3'd2,
		CFG_DATA_HOLD  = 3'd3,
		CFG_SCL_LOW    = 3'd4,
		CFG_SCL_HIGH   = 3'd5,
		CFG_STOP_SETUP = 3'd6
	} cfg_idx_t;

	localparam logic [TimeW-1:0] RST_FALL       = 16'd300;
	localparam logic [TimeW-1:0] RST_RISE       = 16'd1000;
	localparam logic [TimeW-1:0] RST_START_HOLD = 16'd4000;
	localparam logic [TimeW-1:0] RST_DATA_HOLD  = 16'd0;
	localparam logic [TimeW-1:0] RST_SCL_LOW    = 16'd4700;
	localparam logic [TimeW-1:0] RST_SCL_HIGH   = 16'd4000;
	localparam logic [TimeW-1:0] RST_STOP_SETUP = 16'd4000;

	typedef enum logic [2:0] {
		PH_LEAD = 3'b001,
		PH_RISE = 3'b010,
		PH_FALL = 3'b100
	} phase_t;

	typedef struct packed {
		logic [DelayW-1:0] delay;
		logic              sda;
		logic              scl;
		logic              sda_chg;
		logic              scl_chg;
		logic              last;
	} evt_t;

	function automatic logic [DelayW-1:0] add_t(input logic [TimeW-1:0] a,
		input logic [TimeW-1:0] b);
		add_t = {1'b0, a} + {1'b0, b};
	endfunction

endpackage

// File: sv/i2c_waveform_event_generator.sv
// ----------------------------------------------------------------------------
// I2C waveform event generator
// Turns I2C bus symbols into a timed run of SDA/SCL line events.
// ----------------------------------------------------------------------------
// Usage:
//  - Symbol channel (req_valid/req_stall): req_type, symbol_value, read_flag.
//    A symbol transfers when req_valid is high and req_stall is low.
//  - Event channel (evt_valid/evt_stall): delay_ns, line levels, change flags
//    and last_event on the final event of each symbol.
//  - Config port: cfg_we writes cfg_data[15:0] to register cfg_index; write
//    only while no symbol is in flight.
//  - Events: the first event of a symbol goes from the symbol register to the
//    output register. Events leave one per cycle unless evt_stall holds them:
//    idle 1, start 2, stop 2-3, bit 2-3, byte 16-24 events per symbol.
//  - The next symbol transfers in the cycle the current last event is loaded,
//    so symbols run back to back with no gap cycle.
//  - Unused symbol codes transfer and produce no events.
//  - Reset: registers return to their defaults, SDA is taken as high, both
//    channels empty.
//  - A stall on the event side holds the output register and, once the
//    sequencer has its next event ready, holds the symbol side as well.
// ----------------------------------------------------------------------------
module i2c_waveform_event_generator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [i2cweg_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [i2cweg_pkg::TimeW-1:0]       cfg_data,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [2:0]                         req_type,
	input  logic [7:0]                         symbol_value,
	input  logic                               read_flag,
	output logic                               evt_valid,
	input  logic                               evt_stall,
	output logic [i2cweg_pkg::DelayW-1:0]      delay_ns,
	output logic                               sda_level,
	output logic                               scl_level,
	output logic                               sda_changed,
	output logic                               scl_changed,
	output logic                               last_event
);

	logic [i2cweg_pkg::TimeW-1:0] fall_q, rise_q, shold_q, dhold_q, low_q, high_q, ssetup_q;

	logic                          busy_q;
	i2cweg_pkg::req_t              req_s1;
	logic [7:0]                    byte_s1;
	logic [2:0]                    bit_idx_q;
	i2cweg_pkg::phase_t            phase_q;
	logic [i2cweg_pkg::DelayW-1:0] first_q;
	logic                          sda_q;
	logic                          out_valid_q;
	i2cweg_pkg::evt_t              out_q;

	i2cweg_pkg::evt_t              ev;
	i2cweg_pkg::phase_t            ph_eff;
	logic [i2cweg_pkg::DelayW-1:0] first_eff;
	logic                          out_load;
	logic                          emit;
	logic                          req_acc;
	logic                          cur_bit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fall_q   <= i2cweg_pkg::RST_FALL;
			rise_q   <= i2cweg_pkg::RST_RISE;
			shold_q  <= i2cweg_pkg::RST_START_HOLD;
			dhold_q  <= i2cweg_pkg::RST_DATA_HOLD;
			low_q    <= i2cweg_pkg::RST_SCL_LOW;
			high_q   <= i2cweg_pkg::RST_SCL_HIGH;
			ssetup_q <= i2cweg_pkg::RST_STOP_SETUP;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cweg_pkg::CFG_FALL:       fall_q   <= cfg_data;
				i2cweg_pkg::CFG_RISE:       rise_q   <= cfg_data;
				i2cweg_pkg::CFG_START_HOLD: shold_q  <= cfg_data;
				i2cweg_pkg::CFG_DATA_HOLD:  dhold_q  <= cfg_data;
				i2cweg_pkg::CFG_SCL_LOW:    low_q    <= cfg_data;
				i2cweg_pkg::CFG_SCL_HIGH:   high_q   <= cfg_data;
				i2cweg_pkg::CFG_STOP_SETUP: ssetup_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cur_bit  = byte_s1[bit_idx_q];
	assign out_load = !out_valid_q || !evt_stall;
	assign emit     = busy_q && out_load;
	assign req_stall = busy_q && !(out_load && ev.last);
	assign req_acc  = req_valid && !req_stall;

	// event for the current sequencer position; a stop or bit lead phase with no
	// SDA change is skipped within the same cycle
	always_comb begin
		logic [i2cweg_pkg::DelayW:0]   diff;
		logic [i2cweg_pkg::DelayW-1:0] lr;
		ph_eff    = phase_q;
		first_eff = first_q;
		if (phase_q == i2cweg_pkg::PH_LEAD) begin
			first_eff = '0;
			if ((req_s1 == i2cweg_pkg::REQ_STOP && !sda_q) ||
			    ((req_s1 == i2cweg_pkg::REQ_BIT || req_s1 == i2cweg_pkg::REQ_DATA ||
			      req_s1 == i2cweg_pkg::REQ_ADDR) && sda_q == cur_bit))
				ph_eff = i2cweg_pkg::PH_RISE;
		end
		lr   = i2cweg_pkg::add_t(low_q, rise_q);
		diff = {1'b0, lr} - {1'b0, first_eff};
		ev   = '0;
		case (req_s1)
			i2cweg_pkg::REQ_IDLE: begin
				ev.sda  = 1'b1;
				ev.scl  = 1'b1;
				ev.last = 1'b1;
			end
			i2cweg_pkg::REQ_START: begin
				if (phase_q == i2cweg_pkg::PH_LEAD) begin
					ev.delay   = {1'b0, fall_q};
					ev.scl     = 1'b1;
					ev.sda_chg = sda_q;
				end else begin
					ev.delay   = i2cweg_pkg::add_t(shold_q, fall_q);
					ev.scl_chg = 1'b1;
					ev.last    = 1'b1;
				end
			end
			i2cweg_pkg::REQ_STOP: begin
				case (ph_eff)
					i2cweg_pkg::PH_LEAD: begin
						ev.delay   = i2cweg_pkg::add_t(dhold_q, fall_q);
						ev.sda_chg = 1'b1;
					end
					i2cweg_pkg::PH_RISE: begin
						ev.delay   = diff[i2cweg_pkg::DelayW] ? '0 :
						             diff[i2cweg_pkg::DelayW-1:0];
						ev.scl     = 1'b1;
						ev.scl_chg = 1'b1;
					end
					default: begin
						ev.delay   = i2cweg_pkg::add_t(ssetup_q, rise_q);
						ev.sda     = 1'b1;
						ev.scl     = 1'b1;
						ev.sda_chg = 1'b1;
						ev.last    = 1'b1;
					end
				endcase
			end
			default: begin
				ev.sda = cur_bit;
				case (ph_eff)
					i2cweg_pkg::PH_LEAD: begin
						ev.delay   = i2cweg_pkg::add_t(dhold_q, cur_bit ? rise_q : fall_q);
						ev.sda_chg = 1'b1;
					end
					i2cweg_pkg::PH_RISE: begin
						ev.delay   = diff[i2cweg_pkg::DelayW] ? '0 :
						             diff[i2cweg_pkg::DelayW-1:0];
						ev.scl     = 1'b1;
						ev.scl_chg = 1'b1;
					end
					default: begin
						ev.delay   = i2cweg_pkg::add_t(high_q, fall_q);
						ev.scl_chg = 1'b1;
						ev.last    = (bit_idx_q == 3'd0);
					end
				endcase
			end
		endcase
	end

	// symbol register and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			sda_q     <= 1'b1;
			phase_q   <= i2cweg_pkg::PH_LEAD;
			bit_idx_q <= '0;
		end else begin
			if (emit) begin
				sda_q <= ev.sda;
			end
			if (req_acc) begin
				busy_q  <= (req_type <= 3'(i2cweg_pkg::REQ_ADDR));
				phase_q <= i2cweg_pkg::PH_LEAD;
				if (req_type == i2cweg_pkg::REQ_DATA || req_type == i2cweg_pkg::REQ_ADDR)
					bit_idx_q <= 3'd7;
				else
					bit_idx_q <= 3'd0;
			end else if (emit) begin
				if (ev.last) begin
					busy_q <= 1'b0;
				end else if (ph_eff == i2cweg_pkg::PH_LEAD) begin
					phase_q <= i2cweg_pkg::PH_RISE;
				end else if (ph_eff == i2cweg_pkg::PH_RISE) begin
					phase_q <= i2cweg_pkg::PH_FALL;
				end else begin
					phase_q   <= i2cweg_pkg::PH_LEAD;
					bit_idx_q <= bit_idx_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= i2cweg_pkg::req_t'(req_type);
			case (req_type)
				i2cweg_pkg::REQ_ADDR: byte_s1 <= {symbol_value[6:0], read_flag};
				i2cweg_pkg::REQ_BIT:  byte_s1 <= {7'd0, symbol_value[0]};
				default:              byte_s1 <= symbol_value;
			endcase
		end
		if (emit && ph_eff == i2cweg_pkg::PH_LEAD)
			first_q <= ev.delay;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= ev;
	end

	assign evt_valid   = out_valid_q;
	assign delay_ns    = out_q.delay;
	assign sda_level   = out_q.sda;
	assign scl_level   = out_q.scl;
	assign sda_changed = out_q.sda_chg;
	assign scl_changed = out_q.scl_chg;
	assign last_event  = out_q.last;

endmodule

// File: sv/i2cweg_checker.sv
// ----------------------------------------------------------------------------
// I2C waveform event generator port checker
// Watches event hold, line event ordering and symbol transfers during a stall.
// ----------------------------------------------------------------------------
`include "i2c_waveform_event_generator_assert.svh"

module i2cweg_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          evt_valid,
	input logic                          evt_stall,
	input logic [i2cweg_pkg::DelayW-1:0] delay_ns,
	input logic                          sda_level,
	input logic                          scl_level,
	input logic                          sda_changed,
	input logic                          scl_changed,
	input logic                          last_event
);

	logic                          sda_seen_q;
	logic                          req_live;

	// last SDA level shown on a transferred event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sda_seen_q <= 1'b1;
		else if (evt_valid && !evt_stall)
			sda_seen_q <= sda_level;
	end

	assign req_live = req_valid && !req_stall;

	`I2CWEG_ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && evt_stall,
		evt_valid && $stable(delay_ns) && $stable(last_event) && $stable(sda_level))
	`I2CWEG_ASSERT_NOW(a_one_line, clk, arst_n, evt_valid,
		!(sda_changed && scl_changed))
	`I2CWEG_ASSERT_NOW(a_start_stop, clk, arst_n, evt_valid && sda_changed && scl_level,
		sda_level == last_event)
	`I2CWEG_ASSERT_NOW(a_sda_edge, clk, arst_n, evt_valid && sda_changed,
		sda_level != sda_seen_q)
	`I2CWEG_ASSERT_NEXT(a_no_accept_while_full, clk, arst_n,
		req_live && evt_valid && evt_stall, evt_valid)

endmodule

bind i2c_waveform_event_generator i2cweg_checker u_i2cweg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.evt_valid   (evt_valid),
	.evt_stall   (evt_stall),
	.delay_ns    (delay_ns),
	.sda_level   (sda_level),
	.scl_level   (scl_level),
	.sda_changed (sda_changed),
	.scl_changed (scl_changed),
	.last_event  (last_event)
);
